// ----- hw/rtl/fpmk_pkg.sv -----
// fpmk_pkg: shared types and constants for the front panel menu key handler
// used by fpmk_update and front_panel_menu_keys; no dependencies
`timescale 1ns / 1ps

package fpmk_pkg;

  // key pin widths and bit positions (active-low pins)
  localparam int unsigned KeyW       = 3;
  localparam int unsigned KeyUpBit   = 0;
  localparam int unsigned KeyDownBit = 1;
  localparam int unsigned KeyMenuBit = 2;

  // field widths
  localparam int unsigned DelayW   = 16;
  localparam int unsigned VoltW    = 3;
  localparam int unsigned TriggerW = 8;
  localparam int unsigned GridW    = 2;

  // menu codes, as shown on the menu_index field
  typedef enum logic [2:0] {
    MENU_TIME     = 3'd0,
    MENU_VOLT     = 3'd1,
    MENU_TRIGGER  = 3'd2,
    MENU_COUPLING = 3'd3,
    MENU_GRID     = 3'd4
  } menu_e;

  localparam logic [VoltW-1:0]    VoltMax         = 3'd6;
  localparam logic [DelayW-1:0]   TimeStepReset   = 16'd100;
  localparam logic [TriggerW-1:0] TriggerReset    = 8'd128;
  localparam logic [GridW-1:0]    GridReset       = 2'd3;

  // configuration register map
  localparam int unsigned         PaddrW        = 3;
  localparam logic [PaddrW-1:0]   AddrTimeStep  = 3'd0;

  // everything the panel remembers between samples, besides the key history
  typedef struct packed {
    menu_e                menu;
    logic [DelayW-1:0]    delay;
    logic [VoltW-1:0]     volt;
    logic [TriggerW-1:0]  trigger;
    logic                 ac;
    logic [GridW-1:0]     grid;
  } settings_t;

  localparam settings_t SettingsReset = '{
    menu:    MENU_TIME,
    delay:   '0,
    volt:    '0,
    trigger: TriggerReset,
    ac:      1'b0,
    grid:    GridReset
  };

endpackage

// ----- hw/rtl/fpmk_update.sv -----
// fpmk_update: edge detect on the key pins and next-value logic for the settings
// depends on fpmk_pkg
`timescale 1ns / 1ps

module fpmk_update (
  input  logic [fpmk_pkg::KeyW-1:0]   keys_cur_i,
  input  logic [fpmk_pkg::KeyW-1:0]   keys_prev_i,
  input  logic [fpmk_pkg::DelayW-1:0] time_step_i,
  input  fpmk_pkg::settings_t         cur_i,
  output fpmk_pkg::settings_t         next_o,
  output logic                        menu_changed_o
);
  import fpmk_pkg::*;

  logic [KeyW-1:0] pressed;
  logic            up_only;
  logic            down_only;
  logic            adjust;

  // falling edge on an active-low pin
  assign pressed   = ~keys_cur_i & keys_prev_i;
  assign up_only   = pressed[KeyUpBit] & ~pressed[KeyDownBit];
  assign down_only = pressed[KeyDownBit] & ~pressed[KeyUpBit];
  assign adjust    = up_only | down_only;
  assign menu_changed_o = pressed[KeyMenuBit];

  always_comb begin
    next_o = cur_i;

    // menu advance modulo 5
    if (pressed[KeyMenuBit]) begin
      case (cur_i.menu)
        MENU_TIME:     next_o.menu = MENU_VOLT;
        MENU_VOLT:     next_o.menu = MENU_TRIGGER;
        MENU_TRIGGER:  next_o.menu = MENU_COUPLING;
        MENU_COUPLING: next_o.menu = MENU_GRID;
        MENU_GRID:     next_o.menu = MENU_TIME;
        default:       next_o.menu = menu_e'(cur_i.menu - 3'd4);
      endcase
    end

    // setting of the menu that was current before the advance
    if (adjust) begin
      case (cur_i.menu)
        MENU_TIME: begin
          next_o.delay = up_only ? cur_i.delay + time_step_i
                                 : cur_i.delay - time_step_i;
        end
        MENU_VOLT: begin
          if (up_only && cur_i.volt < VoltMax) begin
            next_o.volt = cur_i.volt + 3'd1;
          end else if (down_only && cur_i.volt != '0) begin
            next_o.volt = cur_i.volt - 3'd1;
          end
        end
        MENU_TRIGGER: begin
          next_o.trigger = up_only ? cur_i.trigger + 8'd1 : cur_i.trigger - 8'd1;
        end
        MENU_COUPLING: begin
          next_o.ac = ~cur_i.ac;
        end
        MENU_GRID: begin
          next_o.grid = up_only ? cur_i.grid + 2'd1 : cur_i.grid - 2'd1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/front_panel_menu_keys.sv -----
// front_panel_menu_keys: top level of the front panel menu key handler
// depends on fpmk_pkg and fpmk_update
`timescale 1ns / 1ps

// Takes one key scan sample per request on the input stream (three raw
// active-low pins: up, down, menu) and returns one result request per sample
// holding the menu index, a menu-changed flag and all five settings after the
// sample is applied. A key acts on a high-to-low transition between samples;
// the menu key steps through time, volt, trigger, coupling and grid, and up or
// down changes the setting of the menu shown before the step (both together do
// nothing). The path is an input register, one level of update logic and a
// result register, so a new sample is taken every cycle unless the result
// stream stalls; an accepted sample passes the input register and then the
// result register before result valid rises. When the result register is
// held by backpressure the input register holds too, and input tready drops
// once both are full. The time step is set through the APB port at address 0
// and should only be written while no sample is in flight.
module front_panel_menu_keys (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [2:0] keys_raw
  // result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] menu_index, [3] menu_changed, [19:4] time_delay, [22:20] volt_select,
  // [30:23] trigger_level, [31] ac_coupled, [33:32] grid_select
  output logic [39:0]                  m_axis_tdata,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fpmk_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import fpmk_pkg::*;

  // configuration register
  logic [DelayW-1:0] time_step_q;
  logic              cfg_sel;   // word address matches the time step register
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[PaddrW-1:2] == AddrTimeStep[PaddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite & pready & cfg_sel;
  assign prdata  = cfg_sel ? {16'd0, time_step_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= TimeStepReset;
    end else if (cfg_wr) begin
      time_step_q <= pwdata[DelayW-1:0];
    end
  end

  // input register
  logic            in_valid_q;
  logic [KeyW-1:0] in_keys_q;
  logic            out_valid_q;
  logic            out_load;   // input register moves into the result register

  assign out_load      = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_keys_q <= s_axis_tdata[KeyW-1:0];
    end
  end

  // panel state, advanced once per sample as it enters the result register
  logic [KeyW-1:0] prev_keys_q;
  settings_t       set_q;
  settings_t       set_d;
  logic            menu_changed;

  fpmk_update u_update (
    .keys_cur_i     (in_keys_q),
    .keys_prev_i    (prev_keys_q),
    .time_step_i    (time_step_q),
    .cur_i          (set_q),
    .next_o         (set_d),
    .menu_changed_o (menu_changed)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_keys_q <= '0;
      set_q       <= SettingsReset;
    end else if (out_load) begin
      prev_keys_q <= in_keys_q;
      set_q       <= set_d;
    end
  end

  // result register
  logic [39:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {6'd0, set_d.grid, set_d.ac, set_d.trigger, set_d.volt,
                     set_d.delay, menu_changed, set_d.menu};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
